// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define TCB_ASSERT_NEVER(lbl, cond, msg) \
  `TCB_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/tcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcb_pkg;

  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int ENTRY_BYTES = 4;
  localparam int CELL_W      = 8 * ENTRY_BYTES;

  // Cell layout from the lowest byte up: character, fg, bg, attribute.
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_FG   = 8'd7;
  localparam logic [7:0] RESET_BG   = 8'd0;
  localparam logic [CELL_W-1:0] RESET_CELL = {8'd0, RESET_BG, RESET_FG, BLANK_CHAR};

  typedef enum logic [2:0] {
    MODE_PUT    = 3'd0,
    MODE_CHAR   = 3'd1,
    MODE_COLORS = 3'd2,
    MODE_ATTR   = 3'd3,
    MODE_FILL   = 3'd4,
    MODE_SCROLL = 3'd5,
    MODE_CLEAR  = 3'd6,
    MODE_READ   = 3'd7
  } tcb_mode_t;

  localparam logic [ENTRY_BYTES-1:0] MASK_ALL    = 4'b1111;
  localparam logic [ENTRY_BYTES-1:0] MASK_CHAR   = 4'b0001;
  localparam logic [ENTRY_BYTES-1:0] MASK_COLORS = 4'b0110;
  localparam logic [ENTRY_BYTES-1:0] MASK_ATTR   = 4'b1000;

  // Command from the sequencer to the cell walker.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             down;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_first;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] offset;
  } tcb_walk_cmd_t;

endpackage

`default_nettype wire

// ===== sv/tcb_cell_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcb_cell_mem #(
  parameter int AW = 12
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [tcb_pkg::ENTRY_BYTES-1:0] wmask,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic [tcb_pkg::CELL_W-1:0]      wdata,
  input  wire logic                            re,
  input  wire logic [AW-1:0]                   raddr,
  output logic      [tcb_pkg::CELL_W-1:0]      rdata
);
  import tcb_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [CELL_W-1:0] cells_r [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < ENTRY_BYTES; i++) begin
        if (wmask[i]) begin
          cells_r[waddr][8*i +: 8] <= wdata[8*i +: 8];
        end
      end
    end
    if (re) begin
      rdata_r <= cells_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/tcb_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Row/column counter that walks a rectangle one cell per step, columns
// ascending, rows up or down, and forms the source row of a copy.
module tcb_walker #(
  parameter int CW = 7,
  parameter int RW = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tcb_pkg::tcb_walk_cmd_t cmd,
  output logic      [RW-1:0]         row,
  output logic      [CW-1:0]         col,
  output logic      [RW-1:0]         src_row,
  output logic                       last
);
  import tcb_pkg::*;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_last_r, row_last_nxt;
  logic [CW-1:0] col_first_r, col_first_nxt;
  logic [CW-1:0] col_last_r, col_last_nxt;
  logic [RW-1:0] off_r, off_nxt;
  logic          down_r, down_nxt;
  logic          col_end;

  assign col_end = (col_r == col_last_r);
  assign last    = col_end && (row_r == row_last_r);
  assign src_row = down_r ? (row_r - off_r) : (row_r + off_r);
  assign row     = row_r;
  assign col     = col_r;

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_last_nxt  = row_last_r;
    col_first_nxt = col_first_r;
    col_last_nxt  = col_last_r;
    off_nxt       = off_r;
    down_nxt      = down_r;
    if (cmd.load) begin
      row_nxt       = cmd.row_first[RW-1:0];
      col_nxt       = cmd.col_first[CW-1:0];
      row_last_nxt  = cmd.row_last[RW-1:0];
      col_first_nxt = cmd.col_first[CW-1:0];
      col_last_nxt  = cmd.col_last[CW-1:0];
      off_nxt       = cmd.offset[RW-1:0];
      down_nxt      = cmd.down;
    end else if (cmd.step) begin
      if (col_end) begin
        col_nxt = col_first_r;
        row_nxt = down_r ? (row_r - 1'b1) : (row_r + 1'b1);
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      row_last_r  <= '0;
      col_first_r <= '0;
      col_last_r  <= '0;
      off_r       <= '0;
      down_r      <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      row_last_r  <= row_last_nxt;
      col_first_r <= col_first_nxt;
      col_last_r  <= col_last_nxt;
      off_r       <= off_nxt;
      down_r      <= down_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_cell_buffer_engine.sv =====
// Single-cell commands and reads: the cell is written or read in ST_DECODE, the result registered
// in ST_FIN. Fill and clear write one cell per cycle in ST_FILL; scroll moves each cell via
// ST_COPY_RD and ST_COPY_WR, then blanks the vacated rows in ST_FILL. All cell traffic goes
// through one write and one read port. Reset (rst_n low, synchronous) clears control state,
// then ST_INIT and ST_WIPE set every cell to a space with fg 7, bg 0, attr 0; no item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_cell_buffer_engine #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // col[6:0], row[11:7], col_end[18:12], row_end[23:19], char_code[31:24],
  // fg_color[39:32], bg_color[47:40], attribute[55:48], scroll_amount[61:56], zero[63:62]
  input  wire logic [63:0] in_tdata,
  input  wire logic [2:0]  in_tuser,   // mode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_char[7:0], out_fg[15:8], out_bg[23:16], out_attr[31:24]
  output logic      [31:0] out_tdata,
  output logic      [0:0]  out_tuser   // status[0]
);
  import tcb_pkg::*;

  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW = CW + RW;

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_WIPE    = 8'b0000_0010,
    ST_IDLE    = 8'b0000_0100,
    ST_DECODE  = 8'b0000_1000,
    ST_FILL    = 8'b0001_0000,
    ST_COPY_RD = 8'b0010_0000,
    ST_COPY_WR = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } tcb_state_t;

  tcb_state_t state_r, state_nxt;

  // Item fields, held for the whole command.
  tcb_mode_t         mode_r;
  logic [COL_W-1:0]  col_r, col_end_r;
  logic [ROW_W-1:0]  row_r, row_end_r;
  logic [7:0]        char_r, fg_r, bg_r, attr_r;
  logic signed [5:0] amt_r;

  logic [CELL_W-1:0] fill_data_r, fill_data_nxt;
  logic [ROW_W-1:0]  k_r, k_nxt;
  logic              down_r, down_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic              out_status_r, out_status_nxt;

  tcb_walk_cmd_t     wcmd;
  logic [RW-1:0]     walk_row, walk_src;
  logic [CW-1:0]     walk_col;
  logic              walk_last;

  logic                   mem_we, mem_re;
  logic [ENTRY_BYTES-1:0] mem_mask;
  logic [AW-1:0]          mem_waddr, mem_raddr, cell_addr, walk_addr;
  logic [CELL_W-1:0]      mem_wdata, mem_rdata;

  logic             on_screen, single_cell, fill_ok, big_scroll;
  logic [COL_W-1:0] col_clamp;
  logic [ROW_W-1:0] row_clamp;
  logic [5:0]       k_abs;
  logic [CELL_W-1:0] item_cell, blank_cell;

  assign on_screen   = ({1'b0, col_r} < 8'(COLS)) && ({1'b0, row_r} < 6'(ROWS));
  assign single_cell = (mode_r == MODE_PUT) || (mode_r == MODE_CHAR) ||
                       (mode_r == MODE_COLORS) || (mode_r == MODE_ATTR) ||
                       (mode_r == MODE_READ);
  assign col_clamp   = ({1'b0, col_end_r} >= 8'(COLS)) ? 7'(COLS - 1) : col_end_r;
  assign row_clamp   = ({1'b0, row_end_r} >= 6'(ROWS)) ? 5'(ROWS - 1) : row_end_r;
  assign fill_ok     = (col_r <= col_clamp) && (row_r <= row_clamp);
  assign k_abs       = amt_r[5] ? 6'(-amt_r) : 6'(amt_r);
  assign big_scroll  = (k_abs >= 6'(ROWS));
  assign item_cell   = {attr_r, bg_r, fg_r, char_r};
  assign blank_cell  = {8'd0, bg_r, fg_r, BLANK_CHAR};
  assign cell_addr   = {row_r[RW-1:0], col_r[CW-1:0]};
  assign walk_addr   = {walk_row, walk_col};

  always_comb begin
    state_nxt      = state_r;
    wcmd           = '0;
    mem_we         = 1'b0;
    mem_mask       = MASK_ALL;
    mem_waddr      = walk_addr;
    mem_wdata      = fill_data_r;
    mem_re         = 1'b0;
    mem_raddr      = walk_addr;
    fill_data_nxt  = fill_data_r;
    k_nxt          = k_r;
    down_nxt       = down_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cell_nxt   = out_cell_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_INIT: begin
        wcmd.load     = 1'b1;
        wcmd.row_last = 5'(ROWS - 1);
        wcmd.col_last = 7'(COLS - 1);
        state_nxt     = ST_WIPE;
      end
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        wcmd.step = !walk_last;
        if (walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FIN;
        mem_waddr = cell_addr;
        mem_raddr = cell_addr;
        mem_wdata = item_cell;
        unique case (mode_r)
          MODE_PUT: begin
            mem_we = on_screen;
          end
          MODE_CHAR: begin
            mem_we   = on_screen;
            mem_mask = MASK_CHAR;
          end
          MODE_COLORS: begin
            mem_we   = on_screen;
            mem_mask = MASK_COLORS;
          end
          MODE_ATTR: begin
            mem_we   = on_screen;
            mem_mask = MASK_ATTR;
          end
          MODE_READ: begin
            mem_re = on_screen;
          end
          MODE_FILL: begin
            if (fill_ok) begin
              wcmd.load      = 1'b1;
              wcmd.row_first = row_r;
              wcmd.row_last  = row_clamp;
              wcmd.col_first = col_r;
              wcmd.col_last  = col_clamp;
              fill_data_nxt  = item_cell;
              state_nxt      = ST_FILL;
            end
          end
          MODE_CLEAR: begin
            wcmd.load     = 1'b1;
            wcmd.row_last = 5'(ROWS - 1);
            wcmd.col_last = 7'(COLS - 1);
            fill_data_nxt = blank_cell;
            state_nxt     = ST_FILL;
          end
          MODE_SCROLL: begin
            fill_data_nxt = blank_cell;
            if (big_scroll) begin
              wcmd.load     = 1'b1;
              wcmd.row_last = 5'(ROWS - 1);
              wcmd.col_last = 7'(COLS - 1);
              state_nxt     = ST_FILL;
            end else if (k_abs != 6'd0) begin
              // Moving up walks rows ascending, moving down walks them descending,
              // so no source row is overwritten before it has been read.
              k_nxt         = k_abs[ROW_W-1:0];
              down_nxt      = amt_r[5];
              wcmd.load     = 1'b1;
              wcmd.down     = amt_r[5];
              wcmd.offset   = k_abs[ROW_W-1:0];
              wcmd.col_last = 7'(COLS - 1);
              if (amt_r[5]) begin
                wcmd.row_first = 5'(ROWS - 1);
                wcmd.row_last  = k_abs[ROW_W-1:0];
              end else begin
                wcmd.row_last  = 5'(ROWS - 1) - k_abs[ROW_W-1:0];
              end
              state_nxt = ST_COPY_RD;
            end
          end
        endcase
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        wcmd.step = !walk_last;
        if (walk_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_COPY_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {walk_src, walk_col};
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (walk_last) begin
          // Blank the rows that the move vacated.
          wcmd.load     = 1'b1;
          wcmd.col_last = 7'(COLS - 1);
          if (down_r) begin
            wcmd.row_last = k_r - 1'b1;
          end else begin
            wcmd.row_first = 5'(ROWS) - k_r;
            wcmd.row_last  = 5'(ROWS - 1);
          end
          state_nxt = ST_FILL;
        end else begin
          wcmd.step = 1'b1;
          state_nxt = ST_COPY_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = ((mode_r == MODE_READ) && on_screen) ? mem_rdata : '0;
          out_status_nxt = single_cell && !on_screen;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      down_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      down_r      <= down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_data_r  <= fill_data_nxt;
    out_cell_r   <= out_cell_nxt;
    out_status_r <= out_status_nxt;
    if (in_tvalid && in_tready) begin
      mode_r    <= tcb_mode_t'(in_tuser);
      col_r     <= in_tdata[6:0];
      row_r     <= in_tdata[11:7];
      col_end_r <= in_tdata[18:12];
      row_end_r <= in_tdata[23:19];
      char_r    <= in_tdata[31:24];
      fg_r      <= in_tdata[39:32];
      bg_r      <= in_tdata[47:40];
      attr_r    <= in_tdata[55:48];
      amt_r     <= in_tdata[61:56];
    end
  end

  tcb_walker #(
    .CW (CW),
    .RW (RW)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (wcmd),
    .row     (walk_row),
    .col     (walk_col),
    .src_row (walk_src),
    .last    (walk_last)
  );

  tcb_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .wmask (mem_mask),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cell_r;
  assign out_tuser  = out_status_r;

  `TCB_ASSERT(a_accept_decodes, (in_tvalid && in_tready) |=> (state_r == ST_DECODE),
              "accepted item did not move to decode")
  `TCB_ASSERT_NEVER(a_no_write_when_quiet,
                    mem_we && ((state_r == ST_IDLE) || (state_r == ST_FIN)),
                    "cell write outside a command")
  `TCB_ASSERT(a_result_from_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN),
              "result shown without finishing a command")
  `TCB_ASSERT_NEVER(a_walk_on_screen,
                    ({1'b0, walk_row} >= (RW+1)'(ROWS)) ||
                    ({1'b0, walk_col} >= (CW+1)'(COLS)),
                    "walker left the screen")

endmodule

`default_nettype wire

// ===== tb/cell_buffer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the text cell buffer engine, keeps its own copy of the
// screen, and compares every result against the expected read data and status.
module cell_buffer_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic [0:0]  out_tuser,
  output int               fail_count,
  output int               pending,
  output int               items_seen,
  output int               results_seen,
  output int               reads_seen,
  output int               offscreen_seen
);
  import tcb_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] payload;
    logic              status;
  } cell_result_t;

  logic [CELL_W-1:0] screen [ROWS][COLS];
  cell_result_t      awaited_results [$];

  assign pending = awaited_results.size();

  function automatic logic [CELL_W-1:0] blank_cell(logic [7:0] fg, logic [7:0] bg);
    return {8'd0, bg, fg, BLANK_CHAR};
  endfunction

  // Writes a rectangle; the far corner is clamped, a start past the end writes nothing.
  task automatic paint_rect(int c0, int r0, int c1, int r1, logic [CELL_W-1:0] value);
    if (c1 > COLS - 1) c1 = COLS - 1;
    if (r1 > ROWS - 1) r1 = ROWS - 1;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        screen[r][c] = value;
  endtask

  task automatic scroll_screen(int amount, logic [CELL_W-1:0] blank);
    int k;
    if (amount == 0) return;
    if (amount >= ROWS || -amount >= ROWS) begin
      paint_rect(0, 0, COLS - 1, ROWS - 1, blank);
      return;
    end
    if (amount > 0) begin
      k = amount;
      for (int r = 0; r < ROWS - k; r++)
        for (int c = 0; c < COLS; c++)
          screen[r][c] = screen[r + k][c];
      paint_rect(0, ROWS - k, COLS - 1, ROWS - 1, blank);
    end else begin
      k = -amount;
      for (int r = ROWS - 1; r >= k; r--)
        for (int c = 0; c < COLS; c++)
          screen[r][c] = screen[r - k][c];
      paint_rect(0, 0, COLS - 1, k - 1, blank);
    end
  endtask

  task automatic apply_command(logic [63:0] d, logic [2:0] user);
    tcb_mode_t         mode;
    int                col, row, amount;
    logic [7:0]        ch, fg, bg, attr;
    logic [CELL_W-1:0] entry;
    cell_result_t      res;
    mode   = tcb_mode_t'(user);
    col    = int'(d[6:0]);
    row    = int'(d[11:7]);
    ch     = d[31:24];
    fg     = d[39:32];
    bg     = d[47:40];
    attr   = d[55:48];
    amount = int'($signed(d[61:56]));
    res.payload = '0;
    res.status  = 1'b0;
    case (mode)
      MODE_PUT, MODE_CHAR, MODE_COLORS, MODE_ATTR, MODE_READ: begin
        if (col >= COLS || row >= ROWS) begin
          res.status = 1'b1;
          offscreen_seen++;
        end else begin
          entry = screen[row][col];
          if (mode == MODE_PUT || mode == MODE_CHAR) entry[7:0] = ch;
          if (mode == MODE_PUT || mode == MODE_COLORS) entry[23:8] = {bg, fg};
          if (mode == MODE_PUT || mode == MODE_ATTR) entry[31:24] = attr;
          if (mode == MODE_READ) res.payload = entry;
          screen[row][col] = entry;
        end
        if (mode == MODE_READ) reads_seen++;
      end
      MODE_FILL:   paint_rect(col, row, int'(d[18:12]), int'(d[23:19]), {attr, bg, fg, ch});
      MODE_SCROLL: scroll_screen(amount, blank_cell(fg, bg));
      default:     paint_rect(0, 0, COLS - 1, ROWS - 1, blank_cell(fg, bg));
    endcase
    awaited_results.push_back(res);
    items_seen++;
  endtask

  task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (expected !== actual) begin
      $display("%0t: result %0d field %s expected %h got %h",
               $time, results_seen, name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLS; c++)
          screen[r][c] = RESET_CELL;
    end else begin
      if (in_tvalid && in_tready) apply_command(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none got data %h status %b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          cell_result_t exp_res;
          exp_res = awaited_results.pop_front();
          check_field("char", exp_res.payload[7:0], out_tdata[7:0]);
          check_field("fg", exp_res.payload[15:8], out_tdata[15:8]);
          check_field("bg", exp_res.payload[23:16], out_tdata[23:16]);
          check_field("attr", exp_res.payload[31:24], out_tdata[31:24]);
          check_field("status", {7'd0, exp_res.status}, {7'd0, out_tuser});
        end
        results_seen++;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcb_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int IDLE_LIMIT  = 30000;
  localparam int RANDOM_ITEMS = 430;
  localparam int RAND_DATA   = -1;

  typedef struct {
    tcb_mode_t   mode;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [6:0]  col_end;
    logic [4:0]  row_end;
    logic [7:0]  ch;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  attr;
    logic [5:0]  amount;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  int fail_count, pending, items_seen, results_seen, reads_seen, offscreen_seen;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit no_gaps = 1'b0;
  int last_col = 0;
  int last_row = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_cell_buffer_engine #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  cell_buffer_checker #(.COLS(COLS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending), .items_seen(items_seen),
    .results_seen(results_seen), .reads_seen(reads_seen), .offscreen_seen(offscreen_seen)
  );

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int gap_len();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.mode    = tcb_mode_t'($urandom_range(0, 7));
    c.col     = 7'($urandom);
    c.row     = 5'($urandom);
    c.col_end = 7'($urandom);
    c.row_end = 5'($urandom);
    c.ch      = 8'($urandom);
    c.fg      = 8'($urandom);
    c.bg      = 8'($urandom);
    c.attr    = 8'($urandom);
    c.amount  = 6'($urandom);
    return c;
  endfunction

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_hold = gap_len();
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_command(command_t c);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {2'b00, c.amount, c.attr, c.bg, c.fg, c.ch, c.row_end, c.col_end, c.row, c.col};
    in_tuser  <= c.mode;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // A negative data value leaves the four data bytes random.
  task automatic issue(tcb_mode_t mode, int col, int row, int col_end, int row_end,
                       int amount, int data);
    command_t c;
    c = random_command();
    c.mode    = mode;
    c.col     = col[6:0];
    c.row     = row[4:0];
    c.col_end = col_end[6:0];
    c.row_end = row_end[4:0];
    c.amount  = amount[5:0];
    if (data >= 0) begin
      c.ch   = data[7:0];
      c.fg   = data[7:0];
      c.bg   = data[7:0];
      c.attr = data[7:0];
    end
    send_command(c);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item();
    command_t c;
    int pick;
    c = random_command();
    pick = $urandom_range(0, 99);
    if (pick < 22)      c.mode = MODE_PUT;
    else if (pick < 30) c.mode = MODE_CHAR;
    else if (pick < 38) c.mode = MODE_COLORS;
    else if (pick < 46) c.mode = MODE_ATTR;
    else if (pick < 54) c.mode = MODE_FILL;
    else if (pick < 58) c.mode = MODE_SCROLL;
    else if (pick < 59) c.mode = MODE_CLEAR;
    else                c.mode = MODE_READ;
    case (c.mode)
      MODE_FILL: begin
        c.col = 7'($urandom_range(0, COLS - 1));
        c.row = 5'($urandom_range(0, ROWS - 1));
        // Most fills are small so that the run stays short.
        if ($urandom_range(0, 4) != 0) begin
          c.col_end = 7'(c.col + $urandom_range(0, 6));
          c.row_end = 5'(c.row + $urandom_range(0, 3));
        end
      end
      MODE_SCROLL: begin
        if ($urandom_range(0, 9) < 6) c.amount = 6'($urandom_range(0, 10) - 5);
      end
      MODE_CLEAR: ;
      default: begin
        if (c.mode == MODE_READ && $urandom_range(0, 1) == 0) begin
          c.col = 7'(last_col);
          c.row = 5'(last_row);
        end else if ($urandom_range(0, 9) != 0) begin
          c.col = 7'($urandom_range(0, COLS - 1));
          c.row = 5'($urandom_range(0, ROWS - 1));
        end
        if (c.mode == MODE_PUT) begin
          last_col = int'(c.col);
          last_row = int'(c.row);
        end
      end
    endcase
    send_command(c);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corners, partial writes, off-screen cells, fill clamping, scroll sizes and a clear.
    issue(MODE_READ, 0, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_PUT, 0, 0, 0, 0, 0, 255);
    issue(MODE_PUT, COLS - 1, ROWS - 1, 0, 0, 0, 0);
    issue(MODE_READ, 0, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_READ, COLS - 1, ROWS - 1, 0, 0, 0, RAND_DATA);
    issue(MODE_CHAR, 1, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_COLORS, 1, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_ATTR, 1, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_READ, 1, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_PUT, COLS, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_PUT, 127, 31, 0, 0, 0, RAND_DATA);
    issue(MODE_READ, 0, ROWS, 0, 0, 0, RAND_DATA);
    issue(MODE_COLORS, 100, 3, 0, 0, 0, RAND_DATA);
    issue(MODE_ATTR, 5, 31, 0, 0, 0, RAND_DATA);
    issue(MODE_FILL, 2, 1, 5, 3, 0, RAND_DATA);
    issue(MODE_FILL, 70, 20, 127, 31, 0, RAND_DATA);
    issue(MODE_FILL, 10, 2, 5, 6, 0, RAND_DATA);
    issue(MODE_FILL, 90, 0, 127, 31, 0, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, 0, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, 1, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, -1, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, ROWS - 1, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, 1 - ROWS, RAND_DATA);
    issue(MODE_READ, 3, 1, 0, 0, 0, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, 31, RAND_DATA);
    issue(MODE_SCROLL, 0, 0, 0, 0, -32, RAND_DATA);
    issue(MODE_CLEAR, 0, 0, 0, 0, 0, RAND_DATA);
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS / 2; i++) begin
      // A stretch in the middle runs with no idling on either side.
      no_gaps = (i >= 120 && i < 180);
      random_item();
    end
    no_gaps = 1'b0;
    wait_for_results();
    for (int i = 0; i < RANDOM_ITEMS - RANDOM_ITEMS / 2; i++) random_item();

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands (%0d reads, %0d off-screen cell commands)",
             items_seen, reads_seen, offscreen_seen);
    $display("and checked %0d results over all modes, fill clamping, scrolls and stalls.",
             results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
